### rtl/core/mrpt_pkg.sv
package mrpt_pkg;

    localparam int TableEntries = 16;

    localparam int CmdW    = 2;
    localparam int AddrW   = 32;
    localparam int LenW    = 6;
    localparam int StatusW = 2;

    localparam logic [LenW-1:0] LenMax = LenW'(32);

    // Input and output beat widths
    localparam int InDataW  = 72;
    localparam int OutDataW = 40;

    localparam logic [CmdW-1:0] CmdAdd    = 2'd0;
    localparam logic [CmdW-1:0] CmdDelete = 2'd1;
    localparam logic [CmdW-1:0] CmdLookup = 2'd2;

    localparam logic [StatusW-1:0] StatOk       = 2'd0;
    localparam logic [StatusW-1:0] StatNotFound = 2'd1;
    localparam logic [StatusW-1:0] StatFull     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;    // latch the item, restart the scan
        logic rd_en;   // read one table slot
        logic commit;  // update the table and load the result
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [AddrW-1:0] len_mask(input logic [LenW-1:0] len);
        logic [AddrW-1:0] m;
        if (len >= LenMax) begin
            m = '1;
        end else begin
            m = ~({AddrW{1'b1}} >> len);
        end
        return m;
    endfunction

endpackage

### rtl/core/multicast_rp_prefix_table_top.sv
// Multicast RP prefix table: a table of TABLE_ENTRIES group prefixes, each with an
// RP address. Each slave beat is one command (add/update, delete, lookup); each
// command yields exactly one master beat carrying a status and an RP address.
// Add updates the RP of an equal prefix or fills the lowest free slot (status
// table full when none is left). Delete drops the entry matching prefix, length
// and RP. Lookup returns the RP of the longest covering prefix.
// One command is taken at a time: the beat is taken, then the scan reads one
// table slot per cycle through the single memory read port, then the last read
// lands, and then the command commits.
// The result sits in an output register: a stalled receiver holds it, and the
// next command is still accepted and scanned; only its commit waits for the
// output register to free.
// Reset (synchronous, active low) empties the table at once by clearing all
// valid flags; no clearing pass is needed.
module multicast_rp_prefix_table_top #(
    parameter int TABLE_ENTRIES = mrpt_pkg::TableEntries
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [1:0] command, [33:2] mcast_grp, [39:34] mask_len, [71:40] rp_addr
    input  logic [mrpt_pkg::InDataW-1:0]    i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [1:0] status, [33:2] found_rp, [39:34] zero
    output logic [mrpt_pkg::OutDataW-1:0]   o_m_axis_tdata
);

    mrpt_pkg::t_dp_cmd  dp_cmd;
    mrpt_pkg::t_dp_stat dp_stat;

    logic [mrpt_pkg::StatusW-1:0] status;
    logic [mrpt_pkg::AddrW-1:0]   found_rp;

    mrpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    mrpt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_command    (i_s_axis_tdata[1:0]),
        .i_mcast_grp  (i_s_axis_tdata[33:2]),
        .i_mask_len   (i_s_axis_tdata[39:34]),
        .i_rp_addr    (i_s_axis_tdata[71:40]),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_status     (status),
        .o_found_rp   (found_rp)
    );

    // Pad the result beat to whole bytes
    assign o_m_axis_tdata = {6'd0, found_rp, status};

endmodule

### rtl/core/mrpt_ctrl.sv
module mrpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mrpt_pkg::t_dp_stat i_stat,
    output mrpt_pkg::t_dp_cmd  o_cmd
);

    mrpt_pkg::t_state r_state;
    mrpt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mrpt_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = mrpt_pkg::ST_SCAN;
            end
            mrpt_pkg::ST_SCAN: begin
                if (i_stat.scan_last) n_state = mrpt_pkg::ST_DRAIN;
            end
            mrpt_pkg::ST_DRAIN: begin
                n_state = mrpt_pkg::ST_DONE;
            end
            mrpt_pkg::ST_DONE: begin
                if (i_stat.out_free) n_state = mrpt_pkg::ST_IDLE;
            end
            default: begin
                n_state = mrpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            mrpt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            mrpt_pkg::ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            mrpt_pkg::ST_DRAIN: begin
            end
            mrpt_pkg::ST_DONE: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/core/mrpt_datapath.sv
module mrpt_datapath #(
    parameter int TABLE_ENTRIES = mrpt_pkg::TableEntries
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mrpt_pkg::t_dp_cmd               i_cmd,
    output mrpt_pkg::t_dp_stat              o_stat,
    input  logic [mrpt_pkg::CmdW-1:0]       i_command,
    input  logic [mrpt_pkg::AddrW-1:0]      i_mcast_grp,
    input  logic [mrpt_pkg::LenW-1:0]       i_mask_len,
    input  logic [mrpt_pkg::AddrW-1:0]      i_rp_addr,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mrpt_pkg::StatusW-1:0]    o_status,
    output logic [mrpt_pkg::AddrW-1:0]      o_found_rp
);

    localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
    localparam int WordW = 2 * mrpt_pkg::AddrW + mrpt_pkg::LenW;

    typedef struct packed {
        logic [mrpt_pkg::AddrW-1:0] prefix;
        logic [mrpt_pkg::LenW-1:0]  len;
        logic [mrpt_pkg::AddrW-1:0] rp;
    } t_entry;

    // Latched item
    logic [mrpt_pkg::CmdW-1:0]  r_cmd;
    logic [mrpt_pkg::AddrW-1:0] r_grp;
    logic [mrpt_pkg::LenW-1:0]  r_len;
    logic [mrpt_pkg::AddrW-1:0] r_rp;

    // Table store and valid flags
    logic [WordW-1:0]         r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic [IdxW-1:0] r_rd_idx;
    logic [IdxW-1:0] r_ev_idx;
    logic            r_ev_vld;
    t_entry          r_rd_word;

    // Scan accumulators
    logic            r_hit_fnd, r_free_fnd, r_del_fnd, r_any;
    logic [IdxW-1:0] r_hit_idx, r_free_idx, r_del_idx;
    logic [mrpt_pkg::LenW-1:0]  r_best;
    logic [mrpt_pkg::AddrW-1:0] r_found;

    logic                       r_out_valid;
    logic [mrpt_pkg::StatusW-1:0] r_out_status;
    logic [mrpt_pkg::AddrW-1:0] r_out_rp;

    logic [mrpt_pkg::AddrW-1:0] cmd_mask;
    logic [mrpt_pkg::AddrW-1:0] ent_mask;
    logic                       ev_valid;
    logic                       same_pfx;
    logic                       covers_ent;
    logic                       wr_en;
    logic [IdxW-1:0]            wr_idx;
    logic [mrpt_pkg::StatusW-1:0] res_status;
    logic [mrpt_pkg::AddrW-1:0] res_rp;
    t_entry                     wr_word;

    assign cmd_mask   = mrpt_pkg::len_mask(r_len);
    assign ent_mask   = mrpt_pkg::len_mask(r_rd_word.len);
    assign ev_valid   = r_ev_vld && r_valid[r_ev_idx];
    assign same_pfx   = (r_rd_word.len == r_len) &&
                        ((r_grp & cmd_mask) == (r_rd_word.prefix & cmd_mask));
    assign covers_ent = (r_grp & ent_mask) == (r_rd_word.prefix & ent_mask);

    assign o_stat.scan_last = (r_rd_idx == LastIdx);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // Latch the item; saturate the prefix length
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_grp <= i_mcast_grp;
            r_len <= (i_mask_len > mrpt_pkg::LenMax) ? mrpt_pkg::LenMax : i_mask_len;
            r_rp  <= i_rp_addr;
        end
    end

    // Scan address and read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_ev_vld <= 1'b0;
        end else begin
            r_ev_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_en && r_rd_idx != LastIdx) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_word <= t_entry'(r_mem[r_rd_idx]);
            r_ev_idx  <= r_rd_idx;
        end
        if (wr_en) begin
            r_mem[wr_idx] <= WordW'(wr_word);
        end
    end

    // Accumulate matches; the first slot in index order wins ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_fnd  <= 1'b0;
            r_free_fnd <= 1'b0;
            r_del_fnd  <= 1'b0;
            r_any      <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit_fnd  <= 1'b0;
            r_free_fnd <= 1'b0;
            r_del_fnd  <= 1'b0;
            r_any      <= 1'b0;
        end else if (r_ev_vld) begin
            if (ev_valid) begin
                if (!r_hit_fnd && same_pfx) begin
                    r_hit_fnd <= 1'b1;
                    r_hit_idx <= r_ev_idx;
                end
                if (!r_del_fnd && same_pfx && r_rd_word.rp == r_rp) begin
                    r_del_fnd <= 1'b1;
                    r_del_idx <= r_ev_idx;
                end
                if (covers_ent && (!r_any || r_rd_word.len > r_best)) begin
                    r_any   <= 1'b1;
                    r_best  <= r_rd_word.len;
                    r_found <= r_rd_word.rp;
                end
            end else if (!r_free_fnd) begin
                r_free_fnd <= 1'b1;
                r_free_idx <= r_ev_idx;
            end
        end
    end

    // Result and table update
    always_comb begin
        res_status = mrpt_pkg::StatNotFound;
        res_rp     = '0;
        wr_en      = 1'b0;
        wr_idx     = r_hit_fnd ? r_hit_idx : r_free_idx;
        wr_word.prefix = r_grp & cmd_mask;
        wr_word.len    = r_len;
        wr_word.rp     = r_rp;
        case (r_cmd)
            mrpt_pkg::CmdAdd: begin
                if (r_hit_fnd || r_free_fnd) begin
                    res_status = mrpt_pkg::StatOk;
                    wr_en      = i_cmd.commit;
                end else begin
                    res_status = mrpt_pkg::StatFull;
                end
            end
            mrpt_pkg::CmdDelete: begin
                if (r_del_fnd) res_status = mrpt_pkg::StatOk;
            end
            mrpt_pkg::CmdLookup: begin
                if (r_any) begin
                    res_status = mrpt_pkg::StatOk;
                    res_rp     = r_found;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit) begin
            if (r_cmd == mrpt_pkg::CmdAdd && !r_hit_fnd && r_free_fnd) begin
                r_valid[r_free_idx] <= 1'b1;
            end else if (r_cmd == mrpt_pkg::CmdDelete && r_del_fnd) begin
                r_valid[r_del_idx] <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= res_status;
            r_out_rp     <= res_rp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found_rp  = r_out_rp;

endmodule

### dv/rp_table_checker.sv
module rp_table_checker #(
    parameter int TABLE_ENTRIES = mrpt_pkg::TableEntries
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          i_s_axis_tready,
    // [1:0] command, [33:2] mcast_grp, [39:34] mask_len, [71:40] rp_addr
    input  logic [mrpt_pkg::InDataW-1:0]  i_s_axis_tdata,
    input  logic                          i_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [1:0] status, [33:2] found_rp, [39:34] zero
    input  logic [mrpt_pkg::OutDataW-1:0] i_m_axis_tdata,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count,
    output int                            o_full_count
);

    typedef struct packed {
        logic [mrpt_pkg::StatusW-1:0] status;
        logic [mrpt_pkg::AddrW-1:0]   rp;
    } t_rp_result;

    // Shadow copy of the prefix table
    logic                       route_valid  [TABLE_ENTRIES];
    logic [mrpt_pkg::AddrW-1:0] route_prefix [TABLE_ENTRIES];
    logic [mrpt_pkg::LenW-1:0]  route_len    [TABLE_ENTRIES];
    logic [mrpt_pkg::AddrW-1:0] route_rp     [TABLE_ENTRIES];

    t_rp_result rp_results_due[$];

    function automatic logic [mrpt_pkg::AddrW-1:0] prefix_mask(
        input logic [mrpt_pkg::LenW-1:0] len);
        if (len == 0) begin
            return '0;
        end
        return 32'hFFFF_FFFF << (32 - int'(len));
    endfunction

    // Apply one command to the shadow table and return the status and RP it yields
    function automatic t_rp_result apply_rp_command(
        input logic [mrpt_pkg::InDataW-1:0] beat);
        t_rp_result                 res;
        logic [mrpt_pkg::CmdW-1:0]  cmd;
        logic [mrpt_pkg::AddrW-1:0] grp;
        logic [mrpt_pkg::LenW-1:0]  len;
        logic [mrpt_pkg::AddrW-1:0] rp;
        logic [mrpt_pkg::AddrW-1:0] m;
        int                         hit;
        int                         free_slot;
        logic                       any;
        logic [mrpt_pkg::LenW-1:0]  best;
        cmd       = beat[1:0];
        grp       = beat[33:2];
        len       = beat[39:34];
        rp        = beat[71:40];
        hit       = -1;
        free_slot = -1;
        any       = 1'b0;
        best      = '0;
        res.status = mrpt_pkg::StatNotFound;
        res.rp     = '0;
        if (len > mrpt_pkg::LenMax) begin
            len = mrpt_pkg::LenMax;
        end
        m = prefix_mask(len);
        case (cmd)
            mrpt_pkg::CmdAdd: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (route_valid[i]) begin
                        if (hit < 0 && route_len[i] == len &&
                            ((grp ^ route_prefix[i]) & m) == '0) begin
                            hit = i;
                        end
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (hit >= 0) begin
                    route_rp[hit] = rp;
                    res.status    = mrpt_pkg::StatOk;
                end else if (free_slot >= 0) begin
                    route_valid[free_slot]  = 1'b1;
                    route_prefix[free_slot] = grp & m;
                    route_len[free_slot]    = len;
                    route_rp[free_slot]     = rp;
                    res.status              = mrpt_pkg::StatOk;
                end else begin
                    res.status = mrpt_pkg::StatFull;
                end
            end
            mrpt_pkg::CmdDelete: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (res.status != mrpt_pkg::StatOk && route_valid[i] &&
                        route_rp[i] == rp && route_len[i] == len &&
                        ((grp ^ route_prefix[i]) & m) == '0) begin
                        route_valid[i] = 1'b0;
                        res.status     = mrpt_pkg::StatOk;
                    end
                end
            end
            mrpt_pkg::CmdLookup: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (route_valid[i] &&
                        ((grp ^ route_prefix[i]) & prefix_mask(route_len[i])) == '0 &&
                        (!any || route_len[i] > best)) begin
                        any    = 1'b1;
                        best   = route_len[i];
                        res.rp = route_rp[i];
                    end
                end
                res.status = any ? mrpt_pkg::StatOk : mrpt_pkg::StatNotFound;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rp_result want;
        t_rp_result got;
        int         errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                route_valid[i]  = 1'b0;
                route_prefix[i] = '0;
                route_len[i]    = '0;
                route_rp[i]     = '0;
            end
            rp_results_due.delete();
            o_fail_count   <= 0;
            o_pending      <= 0;
            o_result_count <= 0;
            o_full_count   <= 0;
        end else begin
            // Retire the result beat first: it can never belong to a command taken now
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.status = i_m_axis_tdata[1:0];
                got.rp     = i_m_axis_tdata[33:2];
                o_result_count <= o_result_count + 1;
                if (rp_results_due.size() == 0) begin
                    $error("unexpected result beat: status %0d, found_rp %08h",
                           got.status, got.rp);
                    errs++;
                end else begin
                    want = rp_results_due.pop_front();
                    if (want.status == mrpt_pkg::StatFull) begin
                        o_full_count <= o_full_count + 1;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        errs++;
                    end
                    if (got.rp !== want.rp) begin
                        $error("found_rp: expected %08h, actual %08h", want.rp, got.rp);
                        errs++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                rp_results_due.push_back(apply_rp_command(i_s_axis_tdata));
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= rp_results_due.size();
        end
    end

endmodule

### dv/tb_top.sv
module tb_top;

    // Command code the block answers with not found and no table change
    localparam logic [mrpt_pkg::CmdW-1:0] CmdReserved = 2'd3;

    localparam int RandomPerPhase = 420;

    typedef struct {
        logic [mrpt_pkg::AddrW-1:0] grp;
        logic [mrpt_pkg::LenW-1:0]  len;
        logic [mrpt_pkg::AddrW-1:0] rp;
    } t_route;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_valid = 1'b0;
    // [1:0] command, [33:2] mcast_grp, [39:34] mask_len, [71:40] rp_addr
    logic [mrpt_pkg::InDataW-1:0]  s_data  = '0;
    logic                          s_ready;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    // [1:0] status, [33:2] found_rp, [39:34] zero
    logic [mrpt_pkg::OutDataW-1:0] m_data;

    int fail_count;
    int pending;
    int result_count;
    int full_count;

    // Flow-control knobs, percent of cycles spent idle or stalled
    int send_idle_pct = 0;
    int stall_pct     = 0;

    int     cmd_counts[4] = '{0, 0, 0, 0};
    t_route known_routes[$];

    always #2 i_clk = ~i_clk;

    multicast_rp_prefix_table_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    rp_table_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count),
        .o_full_count    (full_count)
    );

    // Receiver: stall at random, redrawn every cycle on the falling edge
    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("** multicast_rp_prefix_table_top: FAILED **");
        $finish;
    end

    // Drive one command beat; entered and left on a falling edge.
    // Hold valid high across back-to-back beats, drop it only for idle gaps.
    task automatic send_cmd(input logic [mrpt_pkg::CmdW-1:0] cmd,
                            input logic [mrpt_pkg::AddrW-1:0] grp,
                            input logic [mrpt_pkg::LenW-1:0] len,
                            input logic [mrpt_pkg::AddrW-1:0] rp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {rp, len, grp, cmd};
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
        cmd_counts[cmd]++;
    endtask

    // Reuse prefixes of earlier adds for most deletes and lookups and some adds, so
    // updates, deletes and lookups hit; the rest is fresh or random noise.
    task automatic send_random_cmd();
        t_route                     r;
        logic                       have_route;
        int                         sel;
        int                         sat;
        logic [mrpt_pkg::CmdW-1:0]  cmd;
        logic [mrpt_pkg::AddrW-1:0] grp;
        logic [mrpt_pkg::LenW-1:0]  len;
        logic [mrpt_pkg::AddrW-1:0] rp;
        have_route = (known_routes.size() > 0);
        r          = '{grp: '0, len: '0, rp: '0};
        if (have_route) begin
            r = known_routes[$urandom_range(known_routes.size() - 1)];
        end
        sat = (r.len > mrpt_pkg::LenMax) ? 32 : int'(r.len);
        // Fresh groups cluster under four top bytes so prefixes overlap
        grp = ($urandom_range(4) == 0) ? $urandom : {8'hE0 + 8'($urandom_range(3)),
                                                     24'($urandom)};
        sel = $urandom_range(99);
        if (sel < 8) begin
            len = 6'($urandom_range(33, 63));
        end else if (sel < 16) begin
            len = ($urandom_range(1) == 0) ? 6'd0 : 6'd32;
        end else begin
            len = 6'($urandom_range(1, 31));
        end
        rp  = $urandom;
        sel = $urandom_range(99);
        if (sel < 35) begin
            cmd = mrpt_pkg::CmdAdd;
            if (have_route && $urandom_range(99) < 30) begin
                grp = r.grp ^ ($urandom >> sat);
                len = r.len;
            end
            known_routes.push_back(t_route'{grp: grp, len: len, rp: rp});
            if (known_routes.size() > 48) begin
                void'(known_routes.pop_front());
            end
        end else if (sel < 60) begin
            cmd = mrpt_pkg::CmdDelete;
            if (have_route && $urandom_range(99) < 70) begin
                grp = r.grp ^ ($urandom >> sat);
                len = r.len;
                rp  = ($urandom_range(9) == 0) ? $urandom : r.rp;
            end
        end else if (sel < 95) begin
            cmd = mrpt_pkg::CmdLookup;
            if (have_route && $urandom_range(99) < 65) begin
                grp = r.grp ^ ($urandom >> sat);
            end
            len = 6'($urandom);
        end else begin
            cmd = CmdReserved;
            len = 6'($urandom);
        end
        send_cmd(cmd, grp, len, rp);
    endtask

    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        idle_by_phase  = '{0, 84, 0, 36};
        stall_by_phase = '{0, 0, 84, 36};

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, default route, host route, saturation,
        // update, delete hit and miss, reserved command, then fill until full.
        send_cmd(mrpt_pkg::CmdLookup, 32'hE000_0001, 6'd8,  32'h0);
        send_cmd(CmdReserved,         32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF);
        send_cmd(mrpt_pkg::CmdAdd,    32'h0000_0000, 6'd0,  32'hAAAA_0001);
        send_cmd(mrpt_pkg::CmdLookup, 32'h1234_5678, 6'd0,  32'h0);
        send_cmd(mrpt_pkg::CmdAdd,    32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
        send_cmd(mrpt_pkg::CmdAdd,    32'hFFFF_FFFF, 6'h3F, 32'h0000_0005);
        send_cmd(mrpt_pkg::CmdLookup, 32'hFFFF_FFFF, 6'd0,  32'h0);
        send_cmd(mrpt_pkg::CmdAdd,    32'hE1FF_FFFF, 6'd8,  32'h0000_0011);
        send_cmd(mrpt_pkg::CmdAdd,    32'hE100_0000, 6'd8,  32'h0000_0022);
        send_cmd(mrpt_pkg::CmdLookup, 32'hE1AB_CDEF, 6'd0,  32'h0);
        send_cmd(mrpt_pkg::CmdDelete, 32'hE112_3456, 6'd8,  32'h0000_0011);
        send_cmd(mrpt_pkg::CmdDelete, 32'hE112_3456, 6'd8,  32'h0000_0022);
        for (int i = 0; i < mrpt_pkg::TableEntries - 2; i++) begin
            send_cmd(mrpt_pkg::CmdAdd, 32'hE200_0000 | (i << 8), 6'd24,
                     32'h0000_0100 + i);
        end
        send_cmd(mrpt_pkg::CmdAdd,    32'hE300_0000, 6'd24, 32'hDEAD_BEEF);
        send_cmd(mrpt_pkg::CmdLookup, 32'hE200_0D77, 6'd0,  32'h0);

        // Random: free flow, sender gaps, receiver stalls, then both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_by_phase[ph];
            stall_pct     = stall_by_phase[ph];
            repeat (RandomPerPhase) send_random_cmd();
        end
        s_valid <= 1'b0;

        // Drain, then give the block a full scan to show any stray beat
        while (pending != 0) @(posedge i_clk);
        repeat (mrpt_pkg::TableEntries + 8) @(posedge i_clk);

        $display("Sent %0d adds, %0d deletes, %0d lookups, %0d reserved commands",
                 cmd_counts[mrpt_pkg::CmdAdd], cmd_counts[mrpt_pkg::CmdDelete],
                 cmd_counts[mrpt_pkg::CmdLookup], cmd_counts[CmdReserved]);
        $display("over free, gapped, stalled and mixed flow; %0d results checked, %0d full",
                 result_count, full_count);
        if (fail_count == 0) begin
            $display("** multicast_rp_prefix_table_top: PASSED **");
        end else begin
            $display("** multicast_rp_prefix_table_top: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/mrpt_pkg.sv
rtl/core/mrpt_ctrl.sv
rtl/core/mrpt_datapath.sv
rtl/core/multicast_rp_prefix_table_top.sv
dv/rp_table_checker.sv
dv/tb_top.sv
